// ===== hdl/ternary_tree_inference_macros.svh =====
// Assertion macros shared by the ternary tree inference RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef TERNARY_TREE_INFERENCE_MACROS_SVH
`define TERNARY_TREE_INFERENCE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TTI_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tti assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define TTI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tti assertion failed");

`endif

// ===== hdl/tti_pkg.sv =====
// Shared constants, command codes and types for ternary tree inference.
// No dependencies.
package tti_pkg;

   localparam int NODE_TABLE_DEPTH = 1024;
   localparam int FEATURE_COUNT    = 256;
   localparam int MAX_WALK         = 64;

   localparam int NODE_AW = (NODE_TABLE_DEPTH > 1) ? $clog2(NODE_TABLE_DEPTH) : 1;
   localparam int FEAT_AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
   localparam int STEP_W  = $clog2(MAX_WALK + 1);

   localparam int IDX_W  = 10;
   localparam int FIDX_W = 8;
   localparam int VAL_W  = 32;
   localparam int CMD_W  = 2;

   localparam logic [CMD_W-1:0] CMD_WRITE_NODE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_FEAT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVALUATE   = 2'd2;

   typedef struct packed {
      logic [FIDX_W-1:0]       split_feature;
      logic signed [VAL_W-1:0] low_threshold;
      logic signed [VAL_W-1:0] high_threshold;
      logic [IDX_W-1:0]        left_child;
      logic [IDX_W-1:0]        middle_child;
      logic [IDX_W-1:0]        right_child;
      logic signed [VAL_W-1:0] leaf_mean;
   } node_entry_type;

   // operands for the shared threshold compare
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic signed [VAL_W-1:0] low_threshold;
      logic signed [VAL_W-1:0] high_threshold;
      logic                    use_high;
   } cmp_req_type;

endpackage

// ===== hdl/tti_node_mem.sv =====
// Node table memory: one write port, one registered read port.
// Depends on tti_pkg.
module tti_node_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [tti_pkg::NODE_AW-1:0] wr_addr,
   input  tti_pkg::node_entry_type    wr_data,
   input  logic [tti_pkg::NODE_AW-1:0] rd_addr,
   output tti_pkg::node_entry_type    rd_data
);
   import tti_pkg::*;

   node_entry_type mem_ff [NODE_TABLE_DEPTH];
   node_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tti_feat_mem.sv =====
// Row feature memory: one write port, one registered read port.
// Depends on tti_pkg.
module tti_feat_mem (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [tti_pkg::FEAT_AW-1:0]        wr_addr,
   input  logic signed [tti_pkg::VAL_W-1:0]  wr_data,
   input  logic [tti_pkg::FEAT_AW-1:0]        rd_addr,
   output logic signed [tti_pkg::VAL_W-1:0]  rd_data
);
   import tti_pkg::*;

   logic signed [VAL_W-1:0] mem_ff [FEATURE_COUNT];
   logic signed [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/tti_cmp.sv =====
// Shared threshold comparator: value <= selected threshold, signed.
// Depends on tti_pkg.
module tti_cmp (
   input  tti_pkg::cmp_req_type cmp_req,
   output logic                 at_or_below
);
   import tti_pkg::*;

   logic signed [VAL_W-1:0] threshold;

   assign threshold   = cmp_req.use_high ? cmp_req.high_threshold : cmp_req.low_threshold;
   assign at_or_below = (cmp_req.value <= threshold);

endmodule

// ===== hdl/ternary_tree_inference.sv =====
// Ternary tree inference top (tti_pkg, tti_node_mem, tti_feat_mem, tti_cmp, macros header).
// Walk: with a leaf root the result registers after the S_NODE and S_FEAT states; a node
//   left by the low compare adds S_CMP_LO, S_NODE, S_FEAT; by the high, S_CMP_HI as well.
// Flow: one transaction at a time; a write never stalls the input, an evaluation stalls the
//   input until its result registers; a result held by rsp_stall parks the next walk.
// Reset (sync, active high) clears sequencer and result valid; tables are not cleared.
`include "ternary_tree_inference_macros.svh"

module ternary_tree_inference (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tti_pkg::CMD_W-1:0]          req_cmd,
   input  logic [tti_pkg::IDX_W-1:0]          req_node_index,
   input  logic [tti_pkg::FIDX_W-1:0]         req_feature_index,
   input  logic signed [tti_pkg::VAL_W-1:0]   req_feature_value,
   input  logic signed [tti_pkg::VAL_W-1:0]   req_low_threshold,
   input  logic signed [tti_pkg::VAL_W-1:0]   req_high_threshold,
   input  logic [tti_pkg::IDX_W-1:0]          req_left_next,
   input  logic [tti_pkg::IDX_W-1:0]          req_middle_next,
   input  logic [tti_pkg::IDX_W-1:0]          req_right_next,
   input  logic signed [tti_pkg::VAL_W-1:0]   req_leaf_mean,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [tti_pkg::VAL_W-1:0]   rsp_prediction,
   output logic [tti_pkg::IDX_W-1:0]          rsp_leaf_reached,
   output logic                               rsp_walk_overrun
);
   import tti_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_NODE   = 3'd1; // node read in flight
   localparam logic [2:0] S_FEAT   = 3'd2; // node data ready, feature read in flight
   localparam logic [2:0] S_CMP_LO = 3'd3; // compare against low threshold
   localparam logic [2:0] S_CMP_HI = 3'd4; // compare against high threshold

   logic [2:0]        state_ff, state_in;
   logic [IDX_W-1:0]  node_ff, node_in;     // current node of the walk
   logic [STEP_W-1:0] steps_ff, steps_in;   // node-to-child steps taken
   logic              node_ok_ff;           // read address was inside the table
   logic              feat_ok_ff;           // split feature was inside the row

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] rsp_pred_ff, rsp_pred_in;
   logic [IDX_W-1:0]        rsp_leaf_ff, rsp_leaf_in;
   logic                    rsp_over_ff, rsp_over_in;

   logic                    req_accept;
   logic                    out_free;
   logic                    node_wr_en;
   logic                    feat_wr_en;
   node_entry_type          node_wr_data;
   node_entry_type          node_rd;
   logic signed [VAL_W-1:0] feat_rd;
   logic signed [VAL_W-1:0] feat_val;
   logic [IDX_W-1:0]        left_child;
   cmp_req_type             cmp_req;
   logic                    at_or_below;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // table writes, taken only while idle; out-of-range writes are dropped
   assign node_wr_en = req_accept && (req_cmd == CMD_WRITE_NODE)
                       && (32'(req_node_index) < NODE_TABLE_DEPTH);
   assign feat_wr_en = req_accept && (req_cmd == CMD_WRITE_FEAT)
                       && (32'(req_feature_index) < FEATURE_COUNT);

   assign node_wr_data = '{
      split_feature:  req_feature_index,
      low_threshold:  req_low_threshold,
      high_threshold: req_high_threshold,
      left_child:     req_left_next,
      middle_child:   req_middle_next,
      right_child:    req_right_next,
      leaf_mean:      req_leaf_mean
   };

   // node table: read address follows the walk pointer every cycle
   tti_node_mem u_node_mem (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (NODE_AW'(req_node_index)),
      .wr_data (node_wr_data),
      .rd_addr (NODE_AW'(node_ff)),
      .rd_data (node_rd)
   );

   // feature row: read address follows the split feature of the node read
   tti_feat_mem u_feat_mem (
      .clock   (clock),
      .wr_en   (feat_wr_en),
      .wr_addr (FEAT_AW'(req_feature_index)),
      .wr_data (req_feature_value),
      .rd_addr (FEAT_AW'(node_rd.split_feature)),
      .rd_data (feat_rd)
   );

   // range flags line up with the registered read data
   always_ff @(posedge clock) begin
      node_ok_ff <= (32'(node_ff) < NODE_TABLE_DEPTH);
      feat_ok_ff <= (32'(node_rd.split_feature) < FEATURE_COUNT);
   end

   // nodes outside the table act as zero leaves, features outside the row as zero
   assign left_child = node_ok_ff ? node_rd.left_child : '0;
   assign feat_val   = feat_ok_ff ? feat_rd : '0;

   // one comparator serves both thresholds, low first then high
   assign cmp_req = '{
      value:          feat_val,
      low_threshold:  node_rd.low_threshold,
      high_threshold: node_rd.high_threshold,
      use_high:       (state_ff == S_CMP_HI)
   };

   tti_cmp u_cmp (
      .cmp_req     (cmp_req),
      .at_or_below (at_or_below)
   );

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pred_in  = rsp_pred_ff;
      rsp_leaf_in  = rsp_leaf_ff;
      rsp_over_in  = rsp_over_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_cmd == CMD_EVALUATE)) begin
               node_in  = '0;
               steps_in = '0;
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            state_in = S_FEAT;
         end
         S_FEAT: begin
            // leaf or depth cap ends the walk; hold here until the result slot frees
            if (left_child == '0) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_pred_in  = node_ok_ff ? node_rd.leaf_mean : '0;
                  rsp_leaf_in  = node_ff;
                  rsp_over_in  = 1'b0;
                  state_in     = S_IDLE;
               end
            end else if (steps_ff >= STEP_W'(MAX_WALK)) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_pred_in  = '0;
                  rsp_leaf_in  = node_ff;
                  rsp_over_in  = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               state_in = S_CMP_LO;
            end
         end
         S_CMP_LO: begin
            if (at_or_below) begin
               node_in  = left_child;
               steps_in = steps_ff + 1'b1;
               state_in = S_NODE;
            end else begin
               state_in = S_CMP_HI;
            end
         end
         S_CMP_HI: begin
            node_in  = at_or_below ? node_rd.middle_child : node_rd.right_child;
            steps_in = steps_ff + 1'b1;
            state_in = S_NODE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         steps_ff     <= '0;
         node_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         steps_ff     <= steps_in;
         node_ff      <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload holds while valid and stalled
   always_ff @(posedge clock) begin
      rsp_pred_ff <= rsp_pred_in;
      rsp_leaf_ff <= rsp_leaf_in;
      rsp_over_ff <= rsp_over_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prediction   = rsp_pred_ff;
   assign rsp_leaf_reached = rsp_leaf_ff;
   assign rsp_walk_overrun = rsp_over_ff;

   // step count never passes the depth cap during a walk
   `TTI_ASSERT_NOW(a_steps_capped, state_ff != S_IDLE, steps_ff <= STEP_W'(MAX_WALK))
   // a new result appears only at the end of a walk
   `TTI_ASSERT_NEXT(a_rsp_from_walk, !rsp_valid_ff && state_ff != S_FEAT, !rsp_valid_ff)
   // an overrun result always carries a zero prediction
   `TTI_ASSERT_NOW(a_overrun_zero, rsp_valid_ff && rsp_walk_overrun, rsp_prediction == '0)
   // an evaluate transaction starts at the root with no steps taken
   `TTI_ASSERT_NEXT(a_walk_start, req_accept && req_cmd == CMD_EVALUATE,
                    state_ff == S_NODE && node_ff == '0 && steps_ff == '0)

endmodule

// ===== bench/tree_walk_checker.sv =====
// Checker for the ternary tree inference block: watches both channels, predicts each walk.
// Depends on tti_pkg; instantiated by ternary_tree_inference_tb.
module tree_walk_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [tti_pkg::CMD_W-1:0]          req_cmd,
   input  logic [tti_pkg::IDX_W-1:0]          req_node_index,
   input  logic [tti_pkg::FIDX_W-1:0]         req_feature_index,
   input  logic signed [tti_pkg::VAL_W-1:0]   req_feature_value,
   input  logic signed [tti_pkg::VAL_W-1:0]   req_low_threshold,
   input  logic signed [tti_pkg::VAL_W-1:0]   req_high_threshold,
   input  logic [tti_pkg::IDX_W-1:0]          req_left_next,
   input  logic [tti_pkg::IDX_W-1:0]          req_middle_next,
   input  logic [tti_pkg::IDX_W-1:0]          req_right_next,
   input  logic signed [tti_pkg::VAL_W-1:0]   req_leaf_mean,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [tti_pkg::VAL_W-1:0]   rsp_prediction,
   input  logic [tti_pkg::IDX_W-1:0]          rsp_leaf_reached,
   input  logic                               rsp_walk_overrun,
   output int                                 fail_count,
   output int                                 results_owed,
   output int                                 result_count,
   output int                                 overrun_count
);
   import tti_pkg::*;

   typedef struct packed {
      logic signed [VAL_W-1:0] prediction;
      logic [IDX_W-1:0]        leaf_reached;
      logic                    walk_overrun;
   } leaf_result_type;

   node_entry_type          nodes    [NODE_TABLE_DEPTH];
   logic signed [VAL_W-1:0] features [FEATURE_COUNT];
   leaf_result_type         owed_leaves [$];
   int                      fails     = 0;
   int                      results   = 0;
   int                      overruns  = 0;

   // one line per mismatch
   task automatic report(input string what, input logic [VAL_W-1:0] want,
                         input logic [VAL_W-1:0] got);
      fails++;
      $display("%0t MISMATCH %s: expected %h, got %h", $time, what, want, got);
   endtask

   // walk from the root; at most MAX_WALK child steps
   function automatic leaf_result_type walk_tree();
      leaf_result_type         r;
      node_entry_type          e;
      logic [IDX_W-1:0]        n;
      logic signed [VAL_W-1:0] v;
      bit                      done;
      r    = '0;
      n    = '0;
      done = 1'b0;
      for (int steps = 0; steps <= MAX_WALK && !done; steps++) begin
         e = nodes[n];
         if (e.left_child == '0) begin
            r    = '{e.leaf_mean, n, 1'b0};
            done = 1'b1;
         end else if (steps == MAX_WALK) begin
            r    = '{'0, n, 1'b1};
            done = 1'b1;
         end else begin
            v = features[e.split_feature];
            if ($signed(v) <= $signed(e.low_threshold))
               n = e.left_child;
            else if ($signed(v) <= $signed(e.high_threshold))
               n = e.middle_child;
            else
               n = e.right_child;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      leaf_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            case (req_cmd)
               CMD_WRITE_NODE: begin
                  nodes[req_node_index] = '{req_feature_index, req_low_threshold,
                                            req_high_threshold, req_left_next,
                                            req_middle_next, req_right_next,
                                            req_leaf_mean};
               end
               CMD_WRITE_FEAT: begin
                  features[req_feature_index] = req_feature_value;
               end
               CMD_EVALUATE: begin
                  owed_leaves.push_back(walk_tree());
               end
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_leaves.size() == 0) begin
               report("result with no transaction waiting", '0, rsp_prediction);
            end else begin
               want = owed_leaves.pop_front();
               results++;
               if (want.walk_overrun)
                  overruns++;
               if (rsp_prediction !== want.prediction)
                  report("prediction", want.prediction, rsp_prediction);
               if (rsp_leaf_reached !== want.leaf_reached)
                  report("leaf_reached", VAL_W'(want.leaf_reached),
                         VAL_W'(rsp_leaf_reached));
               if (rsp_walk_overrun !== want.walk_overrun)
                  report("walk_overrun", VAL_W'(want.walk_overrun),
                         VAL_W'(rsp_walk_overrun));
            end
         end
      end
      fail_count    <= fails;
      results_owed  <= owed_leaves.size();
      result_count  <= results;
      overrun_count <= overruns;
   end

endmodule

// ===== bench/ternary_tree_inference_tb.sv =====
// Top of the ternary tree inference bench: clock, reset, stimulus and the verdict.
// Depends on tti_pkg, the ternary_tree_inference RTL and tree_walk_checker.
module ternary_tree_inference_tb;
   import tti_pkg::*;

   // cmd 3 has no package name; the block must drop it silently
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int ITEM_TARGET = 450;
   // a capped walk is the longest to reach its result; the tail waits longer than that
   localparam int TAIL_CYCLES = 300;
   // slowest run: ~450 transactions, each a capped walk at worst and slowed by stalls, with margin
   localparam int TIME_LIMIT  = 10_000_000;

   typedef struct {
      logic [CMD_W-1:0]        cmd;
      logic [IDX_W-1:0]        node_index;
      logic [FIDX_W-1:0]       feature_index;
      logic signed [VAL_W-1:0] feature_value;
      node_entry_type          entry;
   } tree_req_type;

   logic                    clock              = 1'b0;
   logic                    reset              = 1'b1;
   logic                    req_valid          = 1'b0;
   logic                    req_stall;
   logic [CMD_W-1:0]        req_cmd            = '0;
   logic [IDX_W-1:0]        req_node_index     = '0;
   logic [FIDX_W-1:0]       req_feature_index  = '0;
   logic signed [VAL_W-1:0] req_feature_value  = '0;
   logic signed [VAL_W-1:0] req_low_threshold  = '0;
   logic signed [VAL_W-1:0] req_high_threshold = '0;
   logic [IDX_W-1:0]        req_left_next      = '0;
   logic [IDX_W-1:0]        req_middle_next    = '0;
   logic [IDX_W-1:0]        req_right_next     = '0;
   logic signed [VAL_W-1:0] req_leaf_mean      = '0;
   logic                    rsp_valid;
   logic                    rsp_stall          = 1'b0;
   logic signed [VAL_W-1:0] rsp_prediction;
   logic [IDX_W-1:0]        rsp_leaf_reached;
   logic                    rsp_walk_overrun;

   int fail_count;
   int results_owed;
   int result_count;
   int overrun_count;

   // idling knobs, percent of cycles
   int sender_idle_pct = 0;
   int stall_pct       = 0;

   int node_writes    = 0;
   int feature_writes = 0;
   int evaluations    = 0;

   // Shadow of what has been written, so no walk ever touches an unwritten entry.
   node_entry_type shadow_nodes [NODE_TABLE_DEPTH];
   bit             node_known   [NODE_TABLE_DEPTH];
   bit             feat_known   [FEATURE_COUNT];
   logic signed [VAL_W-1:0] shadow_feats [FEATURE_COUNT];

   ternary_tree_inference uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_node_index     (req_node_index),
      .req_feature_index  (req_feature_index),
      .req_feature_value  (req_feature_value),
      .req_low_threshold  (req_low_threshold),
      .req_high_threshold (req_high_threshold),
      .req_left_next      (req_left_next),
      .req_middle_next    (req_middle_next),
      .req_right_next     (req_right_next),
      .req_leaf_mean      (req_leaf_mean),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_prediction     (rsp_prediction),
      .rsp_leaf_reached   (rsp_leaf_reached),
      .rsp_walk_overrun   (rsp_walk_overrun)
   );

   tree_walk_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_node_index     (req_node_index),
      .req_feature_index  (req_feature_index),
      .req_feature_value  (req_feature_value),
      .req_low_threshold  (req_low_threshold),
      .req_high_threshold (req_high_threshold),
      .req_left_next      (req_left_next),
      .req_middle_next    (req_middle_next),
      .req_right_next     (req_right_next),
      .req_leaf_mean      (req_leaf_mean),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_prediction     (rsp_prediction),
      .rsp_leaf_reached   (rsp_leaf_reached),
      .rsp_walk_overrun   (rsp_walk_overrun),
      .fail_count         (fail_count),
      .results_owed       (results_owed),
      .result_count       (result_count),
      .overrun_count      (overrun_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure: a fresh coin toss every cycle at the current phase's rate.
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // Hard stop if the block hangs.
   initial begin
      #(TIME_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // Half boundary values or whole-unit Q16.16 steps, half random, so compares often land on equality.
   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         2:       return '0;
         3, 4:    return (int'($urandom_range(8)) - 4) * 65536;
         default: return $urandom;
      endcase
   endfunction

   // Children mostly from a small pool so trees get deep and sometimes loop.
   function automatic logic [IDX_W-1:0] pick_node_index();
      return ($urandom_range(99) < 65) ? IDX_W'($urandom_range(1, 40))
                                       : IDX_W'($urandom_range(1023));
   endfunction

   function automatic logic [FIDX_W-1:0] pick_feature();
      return ($urandom_range(99) < 70) ? FIDX_W'($urandom_range(15))
                                       : FIDX_W'($urandom_range(255));
   endfunction

   // Every field random; callers then overwrite what the command uses, so the
   // don't-care fields still toggle all their bits.
   function automatic tree_req_type random_req();
      tree_req_type     t;
      logic [6*32-1:0] raw_bits;
      raw_bits        = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      t.cmd           = CMD_W'($urandom);
      t.node_index    = IDX_W'($urandom);
      t.feature_index = FIDX_W'($urandom);
      t.feature_value = $urandom;
      t.entry         = raw_bits[$bits(node_entry_type)-1:0];
      return t;
   endfunction

   function automatic tree_req_type random_node(input logic [IDX_W-1:0] idx);
      tree_req_type t;
      t                      = random_req();
      t.cmd                  = CMD_WRITE_NODE;
      t.node_index           = idx;
      t.feature_index        = pick_feature();
      t.entry.split_feature  = t.feature_index;
      t.entry.low_threshold  = pick_value();
      t.entry.high_threshold = pick_value();
      t.entry.left_child     = ($urandom_range(99) < 40) ? '0 : pick_node_index();
      t.entry.middle_child   = ($urandom_range(99) < 10) ? '0 : pick_node_index();
      t.entry.right_child    = ($urandom_range(99) < 10) ? '0 : pick_node_index();
      t.entry.leaf_mean      = $urandom;
      return t;
   endfunction

   // Trace the walk over the shadow; report the first unwritten node or feature it meets.
   function automatic bit first_missing_entry(output bit is_node, output int unsigned idx);
      logic [IDX_W-1:0]        n;
      node_entry_type          e;
      logic signed [VAL_W-1:0] v;
      bit                      stop;
      n       = '0;
      stop    = 1'b0;
      is_node = 1'b0;
      idx     = 0;
      for (int steps = 0; steps <= MAX_WALK && !stop; steps++) begin
         if (!node_known[n]) begin
            is_node = 1'b1;
            idx     = 32'(n);
            return 1'b1;
         end
         e = shadow_nodes[n];
         if (e.left_child == '0 || steps == MAX_WALK) begin
            stop = 1'b1;
         end else if (!feat_known[e.split_feature]) begin
            idx = 32'(e.split_feature);
            return 1'b1;
         end else begin
            v = shadow_feats[e.split_feature];
            if ($signed(v) <= $signed(e.low_threshold))
               n = e.left_child;
            else if ($signed(v) <= $signed(e.high_threshold))
               n = e.middle_child;
            else
               n = e.right_child;
         end
      end
      return 1'b0;
   endfunction

   // Drive one transaction: random sender gap, then hold it until the block takes it.
   // At most one nonblocking write to req_valid per edge.
   task automatic send(input tree_req_type t);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= t.cmd;
      req_node_index     <= t.node_index;
      req_feature_index  <= t.feature_index;
      req_feature_value  <= t.feature_value;
      req_low_threshold  <= t.entry.low_threshold;
      req_high_threshold <= t.entry.high_threshold;
      req_left_next      <= t.entry.left_child;
      req_middle_next    <= t.entry.middle_child;
      req_right_next     <= t.entry.right_child;
      req_leaf_mean      <= t.entry.leaf_mean;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      case (t.cmd)
         CMD_WRITE_NODE: begin
            shadow_nodes[t.node_index]               = t.entry;
            shadow_nodes[t.node_index].split_feature = t.feature_index;
            node_known[t.node_index]                 = 1'b1;
            node_writes++;
         end
         CMD_WRITE_FEAT: begin
            shadow_feats[t.feature_index] = t.feature_value;
            feat_known[t.feature_index]   = 1'b1;
            feature_writes++;
         end
         CMD_EVALUATE: evaluations++;
         default: ;
      endcase
   endtask

   task automatic put_node(input logic [IDX_W-1:0] idx, input logic [FIDX_W-1:0] feat,
                           input logic signed [VAL_W-1:0] lo, input logic signed [VAL_W-1:0] hi,
                           input logic [IDX_W-1:0] l, input logic [IDX_W-1:0] m,
                           input logic [IDX_W-1:0] r, input logic signed [VAL_W-1:0] mean);
      tree_req_type t;
      t               = random_req();
      t.cmd           = CMD_WRITE_NODE;
      t.node_index    = idx;
      t.feature_index = feat;
      t.entry         = '{feat, lo, hi, l, m, r, mean};
      send(t);
   endtask

   task automatic put_feature(input logic [FIDX_W-1:0] idx,
                              input logic signed [VAL_W-1:0] val);
      tree_req_type t;
      t               = random_req();
      t.cmd           = CMD_WRITE_FEAT;
      t.feature_index = idx;
      t.feature_value = val;
      send(t);
   endtask

   task automatic evaluate();
      tree_req_type t;
      t     = random_req();
      t.cmd = CMD_EVALUATE;
      send(t);
   endtask

   // Fill whatever the walk would touch unwritten, then evaluate the row.
   task automatic evaluate_filled();
      bit          is_node;
      int unsigned idx;
      while (first_missing_entry(is_node, idx)) begin
         if (is_node)
            send(random_node(IDX_W'(idx)));
         else
            put_feature(FIDX_W'(idx), pick_value());
      end
      evaluate();
   endtask

   initial begin : stimulus
      tree_req_type t;
      int           items;
      int           pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part, no idling ----
      // root splits on feature 0 into three leaves; extremes of mean and child fields
      put_feature(0, 32'sh7FFF_FFFF);
      put_node(0, 0, 32'sh0000_0000, 32'sh0004_0000, 1, 2, 3, 32'sh0000_1234);
      put_node(1, 0, 32'sh0000_0000, 32'sh0000_0000, 0, 1023, 1023, 32'sh8000_0000);
      put_node(2, 255, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 32'sh7FFF_FFFF);
      put_node(3, 7, 32'sh0000_0000, 32'sh0000_0000, 0, 512, 511, 32'sh0001_8000);
      evaluate();                                  // above high: right
      put_feature(0, 32'sh0000_0000);
      evaluate();                                  // equal to low: left
      put_feature(0, 32'sh0004_0000);
      evaluate();                                  // equal to high: middle
      put_feature(0, 32'sh8000_0000);
      evaluate();                                  // most negative: left
      // node 1023 loops on itself, so a walk into it hits the depth cap
      put_feature(255, 32'sh8000_0000);
      put_node(1023, 255, 32'sh8000_0000, 32'sh7FFF_FFFF, 1023, 1023, 1023, 32'sh0000_0005);
      put_node(0, 255, 32'sh8000_0000, 32'sh7FFF_FFFF, 1023, 1, 2, 32'sh0000_0000);
      evaluate();                                  // min <= min threshold: into the loop
      put_feature(255, 32'sh7FFF_FFFF);
      evaluate();                                  // max <= max threshold: middle leaf
      t     = random_req();                        // unused command, must be dropped
      t.cmd = CMD_UNUSED;
      send(t);
      put_node(0, 0, 32'sh0000_0000, 32'sh0000_0000, 0, 0, 0, 32'sh7FFF_FFFF);
      evaluate();                                  // root itself is a leaf

      // ---- random part: four idling phases ----
      items = node_writes + feature_writes + evaluations;
      while (node_writes + feature_writes + evaluations < items + ITEM_TARGET) begin
         case ((node_writes + feature_writes + evaluations - items) * 4 / ITEM_TARGET)
            0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
            1:       begin sender_idle_pct = 61; stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  stall_pct = 61; end
            default: begin sender_idle_pct = 36; stall_pct = 36; end
         endcase
         pick = $urandom_range(99);
         if (pick < 20) begin
            // rewrite a node, often the root or a pool node, reshaping the tree
            send(random_node(($urandom_range(99) < 15) ? '0 : pick_node_index()));
         end else if (pick < 45) begin
            put_feature(pick_feature(), pick_value());
         end else if (pick < 50) begin
            t     = random_req();
            t.cmd = CMD_UNUSED;
            send(t);
         end else begin
            evaluate_filled();
         end
      end
      req_valid <= 1'b0;

      // let the checker's owed count catch up with the last accepted transaction
      repeat (2) @(posedge clock);
      // drain, then give the block time to show any stray result
      while (results_owed != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d node writes, %0d feature writes, %0d evaluations",
               node_writes, feature_writes, evaluations);
      $display("%0d results checked (%0d depth-capped) across four idling phases",
               result_count, overrun_count);
      if (fail_count == 0 && results_owed == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
